// File: rtl/core/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;

  typedef enum logic [2:0] {
    KIND_ZERO     = 3'd0,
    KIND_NOT_EQ   = 3'd1,
    KIND_TWO_REAL = 3'd2,
    KIND_DOUBLE   = 3'd3,
    KIND_COMPLEX  = 3'd4,
    KIND_DEGEN    = 3'd5
  } kind_t;

  // Per-transaction flags travelling alongside the datapath.
  typedef struct packed {
    kind_t kind;
    logic  special;
    logic  sa;
    logic  sb;
    logic  dneg;
    logic  dzero;
  } side_t;

endpackage

// File: rtl/core/qrs_sqrt_cell.sv
// One digit-by-digit square root cell: resolves one root bit per stage.
`timescale 1ns / 1ps
module qrs_sqrt_cell #(
  parameter int SW = 33,
  parameter int PW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_i,
  input  logic [2*SW-1:0] rad_i,
  input  logic [SW+2:0]   rem_i,
  input  logic [SW-1:0]   root_i,
  input  logic [PW-1:0]   pass_i,
  output logic            valid_o,
  output logic [2*SW-1:0] rad_o,
  output logic [SW+2:0]   rem_o,
  output logic [SW-1:0]   root_o,
  output logic [PW-1:0]   pass_o
);

  localparam int RW = SW + 3;

  logic            valid_r;
  logic [2*SW-1:0] rad_r,  rad_nxt;
  logic [RW-1:0]   rem_r,  rem_nxt;
  logic [SW-1:0]   root_r, root_nxt;
  logic [PW-1:0]   pass_r;
  logic [RW-1:0]   rem_sh, trial;
  logic            ge;

  always_comb begin
    rem_sh   = {rem_i[RW-3:0], rad_i[2*SW-1 -: 2]};
    trial    = {1'b0, root_i, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_i[SW-2:0], ge};
    rad_nxt  = {rad_i[2*SW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      pass_r <= pass_i;
    end
  end

  assign valid_o = valid_r;
  assign rad_o   = rad_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign pass_o  = pass_r;

endmodule

// File: rtl/core/qrs_div_cell.sv
// One restoring divider cell with two lanes sharing a divisor: one quotient bit each.
`timescale 1ns / 1ps
module qrs_div_cell
  import qrs_pkg::*;
#(
  parameter int NW  = 49,
  parameter int DNW = 33
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_i,
  input  logic [DNW-1:0] den_i,
  input  side_t          side_i,
  input  logic [NW-1:0]  num_a_i,
  input  logic [NW-1:0]  num_b_i,
  input  logic [DNW-1:0] rem_a_i,
  input  logic [DNW-1:0] rem_b_i,
  input  logic [NW-1:0]  q_a_i,
  input  logic [NW-1:0]  q_b_i,
  output logic           valid_o,
  output logic [DNW-1:0] den_o,
  output side_t          side_o,
  output logic [NW-1:0]  num_a_o,
  output logic [NW-1:0]  num_b_o,
  output logic [DNW-1:0] rem_a_o,
  output logic [DNW-1:0] rem_b_o,
  output logic [NW-1:0]  q_a_o,
  output logic [NW-1:0]  q_b_o
);

  logic           valid_r;
  logic [DNW-1:0] den_r;
  side_t          side_r;
  logic [NW-1:0]  num_a_r, num_b_r, q_a_r, q_b_r;
  logic [DNW-1:0] rem_a_r, rem_b_r;
  logic [DNW:0]   sh_a, sh_b, dx, dif_a, dif_b;
  logic           ge_a, ge_b;

  always_comb begin
    dx    = {1'b0, den_i};
    sh_a  = {rem_a_i, num_a_i[NW-1]};
    sh_b  = {rem_b_i, num_b_i[NW-1]};
    ge_a  = (sh_a >= dx);
    ge_b  = (sh_b >= dx);
    dif_a = ge_a ? (sh_a - dx) : sh_a;
    dif_b = ge_b ? (sh_b - dx) : sh_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  // remainder stays below the divisor, so the top bit is always clear
  always_ff @(posedge clk) begin
    if (en) begin
      den_r   <= den_i;
      side_r  <= side_i;
      num_a_r <= {num_a_i[NW-2:0], 1'b0};
      num_b_r <= {num_b_i[NW-2:0], 1'b0};
      rem_a_r <= dif_a[DNW-1:0];
      rem_b_r <= dif_b[DNW-1:0];
      q_a_r   <= {q_a_i[NW-2:0], ge_a};
      q_b_r   <= {q_b_i[NW-2:0], ge_b};
    end
  end

  assign valid_o = valid_r;
  assign den_o   = den_r;
  assign side_o  = side_r;
  assign num_a_o = num_a_r;
  assign num_b_o = num_b_r;
  assign rem_a_o = rem_a_r;
  assign rem_b_o = rem_b_r;
  assign q_a_o   = q_a_r;
  assign q_b_o   = q_b_r;

endmodule

// File: rtl/core/quadratic_root_solver.sv
// Top level of the pipelined fixed-point quadratic root solver.
`timescale 1ns / 1ps
// Solves a*x^2 + b*x + c = 0 for signed fixed-point coefficients (Q16.16 by default)
// and returns a root kind plus two saturated values of the same format. A new
// transaction may enter every cycle unless the pipe stalls. It passes through the
// front stages (magnitudes, products, discriminant), (VALUE_WIDTH+1) square root
// cells, (VALUE_WIDTH+FRAC_BITS+1) divider cells, the finish stage and the output
// register. The whole pipe stalls only while an output result is held and not taken.
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_coef_a,
  input  logic signed [VALUE_WIDTH-1:0] in_coef_b,
  input  logic signed [VALUE_WIDTH-1:0] in_coef_c,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_root_kind,
  output logic signed [VALUE_WIDTH-1:0] out_first_value,
  output logic signed [VALUE_WIDTH-1:0] out_second_value,
  output logic                          out_overflow
);

  localparam int W   = VALUE_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DW  = 2*W + 2;
  localparam int SW  = W + 1;
  localparam int NW  = W + F + 1;
  localparam int DNW = W + 1;
  localparam int SDW = $bits(side_t);
  localparam int PW  = DNW + W + SDW;
  localparam int XW  = NW + 2;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: magnitudes, signs, trivial cases
  logic         v0_r;
  logic [W-1:0] ma0_r, mb0_r, mc0_r;
  side_t        sd0_r, sd0_nxt;
  logic [W-1:0] ma_nxt, mb_nxt, mc_nxt;
  logic         sc0_r;

  always_comb begin
    ma_nxt = in_coef_a[W-1] ? (~in_coef_a + 1'b1) : in_coef_a;
    mb_nxt = in_coef_b[W-1] ? (~in_coef_b + 1'b1) : in_coef_b;
    mc_nxt = in_coef_c[W-1] ? (~in_coef_c + 1'b1) : in_coef_c;
    sd0_nxt         = '0;
    sd0_nxt.sa      = in_coef_a[W-1];
    sd0_nxt.sb      = in_coef_b[W-1];
    sd0_nxt.kind    = KIND_TWO_REAL;
    sd0_nxt.special = 1'b0;
    if (ma_nxt == '0 && mb_nxt == '0) begin
      sd0_nxt.special = 1'b1;
      sd0_nxt.kind    = (mc_nxt == '0) ? KIND_ZERO : KIND_NOT_EQ;
    end else if (ma_nxt == '0) begin
      sd0_nxt.special = 1'b1;
      sd0_nxt.kind    = KIND_DEGEN;
    end
  end

  // stage 1: products
  logic          v1_r;
  logic [2*W-1:0] bb1_r;
  logic [DW-1:0]  ac1_r;
  logic [W-1:0]   mb1_r;
  logic [DNW-1:0] den1_r;
  side_t          sd1_r;
  logic           sc1_r;
  logic [2*W-1:0] ac_prod;
  assign ac_prod = ma0_r * mc0_r;

  // stage 2: discriminant magnitude
  logic           v2_r;
  logic [DW-1:0]  dmag2_r, dmag_nxt;
  logic [W-1:0]   mb2_r;
  logic [DNW-1:0] den2_r;
  side_t          sd2_r, sd2_nxt;
  logic [DW-1:0]  bbx;

  always_comb begin
    bbx     = {2'b00, bb1_r};
    sd2_nxt = sd1_r;
    if (sd1_r.sa != sc1_r) begin
      dmag_nxt     = bbx + ac1_r;
      sd2_nxt.dneg = 1'b0;
    end else if (bbx >= ac1_r) begin
      dmag_nxt     = bbx - ac1_r;
      sd2_nxt.dneg = 1'b0;
    end else begin
      dmag_nxt     = ac1_r - bbx;
      sd2_nxt.dneg = 1'b1;
    end
    sd2_nxt.dzero = (dmag_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma0_r   <= ma_nxt;
      mb0_r   <= mb_nxt;
      mc0_r   <= mc_nxt;
      sc0_r   <= in_coef_c[W-1];
      sd0_r   <= sd0_nxt;
      bb1_r   <= mb0_r * mb0_r;
      ac1_r   <= {ac_prod, 2'b00};
      mb1_r   <= mb0_r;
      den1_r  <= {ma0_r, 1'b0};
      sd1_r   <= sd0_r;
      sc1_r   <= sc0_r;
      dmag2_r <= dmag_nxt;
      mb2_r   <= mb1_r;
      den2_r  <= den1_r;
      sd2_r   <= sd2_nxt;
    end
  end

  // square root chain
  logic            sq_v    [0:SW];
  logic [2*SW-1:0] sq_rad  [0:SW];
  logic [SW+2:0]   sq_rem  [0:SW];
  logic [SW-1:0]   sq_root [0:SW];
  logic [PW-1:0]   sq_pass [0:SW];

  assign sq_v[0]    = v2_r;
  assign sq_rad[0]  = dmag2_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_pass[0] = {den2_r, mb2_r, sd2_r};

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell #(.SW(SW), .PW(PW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (sq_v[i]),
      .rad_i   (sq_rad[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .pass_i  (sq_pass[i]),
      .valid_o (sq_v[i+1]),
      .rad_o   (sq_rad[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .pass_o  (sq_pass[i+1])
    );
  end

  // divider chain: lane a gives |b|/2|a|, lane b gives S/2|a|
  logic           dv_v   [0:NW];
  logic [DNW-1:0] dv_den [0:NW];
  side_t          dv_sd  [0:NW];
  logic [NW-1:0]  dv_na  [0:NW];
  logic [NW-1:0]  dv_nb  [0:NW];
  logic [DNW-1:0] dv_ra  [0:NW];
  logic [DNW-1:0] dv_rb  [0:NW];
  logic [NW-1:0]  dv_qa  [0:NW];
  logic [NW-1:0]  dv_qb  [0:NW];

  assign dv_v[0]   = sq_v[SW];
  assign dv_den[0] = sq_pass[SW][PW-1 -: DNW];
  assign dv_sd[0]  = sq_pass[SW][SDW-1:0];
  assign dv_na[0]  = {1'b0, sq_pass[SW][SDW +: W], {F{1'b0}}};
  assign dv_nb[0]  = {sq_root[SW], {F{1'b0}}};
  assign dv_ra[0]  = '0;
  assign dv_rb[0]  = '0;
  assign dv_qa[0]  = '0;
  assign dv_qb[0]  = '0;

  for (genvar j = 0; j < NW; j++) begin : g_div
    qrs_div_cell #(.NW(NW), .DNW(DNW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (dv_v[j]),
      .den_i   (dv_den[j]),
      .side_i  (dv_sd[j]),
      .num_a_i (dv_na[j]),
      .num_b_i (dv_nb[j]),
      .rem_a_i (dv_ra[j]),
      .rem_b_i (dv_rb[j]),
      .q_a_i   (dv_qa[j]),
      .q_b_i   (dv_qb[j]),
      .valid_o (dv_v[j+1]),
      .den_o   (dv_den[j+1]),
      .side_o  (dv_sd[j+1]),
      .num_a_o (dv_na[j+1]),
      .num_b_o (dv_nb[j+1]),
      .rem_a_o (dv_ra[j+1]),
      .rem_b_o (dv_rb[j+1]),
      .q_a_o   (dv_qa[j+1]),
      .q_b_o   (dv_qb[j+1])
    );
  end

  // finish stage 1: apply signs, form both real roots
  logic                 vf_r;
  side_t                sdf_r;
  logic signed [XW-1:0] e_r, f_r, g_r, h_r;
  logic signed [XW-1:0] e_nxt, f_nxt, ea, fa;

  always_comb begin
    ea    = signed'({2'b00, dv_qa[NW]});
    fa    = signed'({2'b00, dv_qb[NW]});
    e_nxt = (dv_sd[NW].sb == dv_sd[NW].sa) ? -ea : ea;
    f_nxt = dv_sd[NW].sa ? -fa : fa;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= dv_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sdf_r <= dv_sd[NW];
      e_r   <= e_nxt;
      f_r   <= f_nxt;
      g_r   <= e_nxt + f_nxt;
      h_r   <= e_nxt - f_nxt;
    end
  end

  // returns {overflow, saturated value}
  function automatic logic [W:0] sat_f(input logic signed [XW-1:0] x);
    logic [XW-W:0] top;
    top = x[XW-1:W-1];
    if (&top || ~|top) begin
      sat_f = {1'b0, x[W-1:0]};
    end else if (x[XW-1]) begin
      sat_f = {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      sat_f = {1'b1, 1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // output register
  logic         ov_r;
  logic [2:0]   kind_r,   kind_nxt;
  logic [W-1:0] v1_out_r, v1_nxt;
  logic [W-1:0] v2_out_r, v2_nxt;
  logic         ovf_r,    ovf_nxt;
  logic [W:0]   se, sf, sg, sh;
  logic signed [XW-1:0] hi, lo;

  always_comb begin
    hi = (g_r < h_r) ? h_r : g_r;
    lo = (g_r < h_r) ? g_r : h_r;
    se = sat_f(e_r);
    sf = sat_f(f_r);
    sg = sat_f(hi);
    sh = sat_f(lo);
    if (sdf_r.special) begin
      kind_nxt = sdf_r.kind;
      v1_nxt   = '0;
      v2_nxt   = '0;
      ovf_nxt  = 1'b0;
    end else if (sdf_r.dzero) begin
      kind_nxt = KIND_DOUBLE;
      v1_nxt   = se[W-1:0];
      v2_nxt   = '0;
      ovf_nxt  = se[W];
    end else if (!sdf_r.dneg) begin
      kind_nxt = KIND_TWO_REAL;
      v1_nxt   = sg[W-1:0];
      v2_nxt   = sh[W-1:0];
      ovf_nxt  = sg[W] | sh[W];
    end else begin
      kind_nxt = KIND_COMPLEX;
      v1_nxt   = se[W-1:0];
      v2_nxt   = sf[W-1:0];
      ovf_nxt  = se[W] | sf[W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r   <= kind_nxt;
      v1_out_r <= v1_nxt;
      v2_out_r <= v2_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_root_kind    = kind_r;
  assign out_first_value  = v1_out_r;
  assign out_second_value = v2_out_r;
  assign out_overflow     = ovf_r;

endmodule
